### design/lcts_pkg.sv
// ----------------------------------------------------------------------------
// lcts_pkg: shared types and constants for the load cell tare and scale block
// Holds the microcode table, the control word layout and the divider bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package lcts_pkg;

   // Datapath widths.
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned FRAC_W    = 16;
   localparam int unsigned DVD_W     = 48;
   localparam int unsigned CNT_W     = 8;
   localparam int unsigned PROD_W    = 39;
   localparam int unsigned CENT_W    = 7;
   localparam int unsigned PC_W      = 4;
   localparam int unsigned CSR_IDX_W = 8;
   localparam int unsigned DSTEP_W   = 6;

   // Number of restoring steps of the shared divider.
   localparam logic [DSTEP_W-1:0] DIV_STEPS = 6'd48;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_FACTOR = 8'd1;

   // Reset values and fixed constants.
   localparam logic [CNT_W-1:0]  RESET_SAMPLE_COUNT = 8'd1;
   localparam logic [WORD_W-1:0] RESET_SCALE_FACTOR = 32'd28875142;
   localparam logic [WORD_W-1:0] CLAMP_LIMIT        = 32'hFFFF_0000;
   localparam logic [CENT_W-1:0] HUNDRED            = 7'd100;

   typedef logic [PC_W-1:0] pc_type;

   // Datapath operations selected by one control word.
   typedef enum logic [2:0] {
      UOP_NONE,
      UOP_LOAD_SAMPLE,
      UOP_ACCUM,
      UOP_NET,
      UOP_MUL,
      UOP_FRAC,
      UOP_EMIT,
      UOP_TARE
   } uop_type;

   // Jump conditions: when true the sequencer goes to the target step,
   // otherwise to the following step.
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_DIV_BUSY,
      COND_BATCH_MORE,
      COND_TARE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      uop_type  uop;
      cond_type cond;
      pc_type   target;
   } ctrl_word_type;

   // Step addresses of the microprogram.
   localparam pc_type STEP_FETCH     = 4'd0;
   localparam pc_type STEP_WAIT_AVG  = 4'd1;
   localparam pc_type STEP_ACCUM     = 4'd2;
   localparam pc_type STEP_BRANCH    = 4'd3;
   localparam pc_type STEP_NET       = 4'd4;
   localparam pc_type STEP_WAIT_UNIT = 4'd5;
   localparam pc_type STEP_MUL       = 4'd6;
   localparam pc_type STEP_FRAC      = 4'd7;
   localparam pc_type STEP_WAIT_FRAC = 4'd8;
   localparam pc_type STEP_EMIT      = 4'd9;
   localparam pc_type STEP_RETURN    = 4'd10;
   localparam pc_type STEP_TARE      = 4'd11;

   // Microprogram read-only table.
   function automatic ctrl_word_type ucode_rom(input pc_type pc);
      ctrl_word_type cw;
      cw = '{uop: UOP_NONE, cond: COND_ALWAYS, target: STEP_FETCH};
      case (pc)
         STEP_FETCH:     cw = '{UOP_LOAD_SAMPLE, COND_NO_REQ,     STEP_FETCH};
         STEP_WAIT_AVG:  cw = '{UOP_NONE,        COND_DIV_BUSY,   STEP_WAIT_AVG};
         STEP_ACCUM:     cw = '{UOP_ACCUM,       COND_BATCH_MORE, STEP_FETCH};
         STEP_BRANCH:    cw = '{UOP_NONE,        COND_TARE,       STEP_TARE};
         STEP_NET:       cw = '{UOP_NET,         COND_NEVER,      STEP_FETCH};
         STEP_WAIT_UNIT: cw = '{UOP_NONE,        COND_DIV_BUSY,   STEP_WAIT_UNIT};
         STEP_MUL:       cw = '{UOP_MUL,         COND_NEVER,      STEP_FETCH};
         STEP_FRAC:      cw = '{UOP_FRAC,        COND_NEVER,      STEP_FETCH};
         STEP_WAIT_FRAC: cw = '{UOP_NONE,        COND_DIV_BUSY,   STEP_WAIT_FRAC};
         STEP_EMIT:      cw = '{UOP_EMIT,        COND_OUT_BUSY,   STEP_EMIT};
         STEP_RETURN:    cw = '{UOP_NONE,        COND_ALWAYS,     STEP_FETCH};
         STEP_TARE:      cw = '{UOP_TARE,        COND_ALWAYS,     STEP_FETCH};
         default:        cw = '{UOP_NONE,        COND_ALWAYS,     STEP_FETCH};
      endcase
      return cw;
   endfunction

   // Divider command and status bundles.
   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dividend;
      logic [WORD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic [DVD_W-1:0]  quotient;
      logic [WORD_W-1:0] remainder;
   } div_rsp_type;

endpackage

`default_nettype wire

### design/lcts_if.sv
// ----------------------------------------------------------------------------
// lcts_if: channel interfaces of the load cell tare and scale block
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

// Sample input channel.
interface lcts_req_if #(
   parameter int ADC_BITS = 24
);
   logic                valid;
   logic                ready;
   logic                mode;
   logic [ADC_BITS-1:0] raw_sample;

   modport source (output valid, output mode, output raw_sample, input ready);
   modport sink   (input valid, input mode, input raw_sample, output ready);
endinterface

// Result output channel.
interface lcts_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [lcts_pkg::WORD_W-1:0]  net_counts;
   logic [lcts_pkg::WORD_W-1:0]  whole_units;
   logic [lcts_pkg::CENT_W-1:0]  hundredths;

   modport source (output valid, output net_counts, output whole_units,
                   output hundredths, input ready);
   modport sink   (input valid, input net_counts, input whole_units,
                   input hundredths, output ready);
endinterface

// Configuration write channel.
interface lcts_csr_if;
   logic                           valid;
   logic                           ready;
   logic [lcts_pkg::CSR_IDX_W-1:0] index;
   logic [lcts_pkg::WORD_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/lcts_div.sv
// ----------------------------------------------------------------------------
// lcts_div: shared restoring divider
// Divides a 48-bit dividend by a 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcts_div (
   input  wire                    clock,
   input  wire                    reset,
   input  lcts_pkg::div_req_type  div_req,
   output lcts_pkg::div_rsp_type  div_rsp
);

   logic [lcts_pkg::DSTEP_W-1:0] count_ff, count_in;
   logic [lcts_pkg::WORD_W-1:0]  rem_ff, rem_in;
   logic [lcts_pkg::DVD_W-1:0]   quo_ff, quo_in;
   logic [lcts_pkg::WORD_W-1:0]  divisor_ff, divisor_in;
   logic [lcts_pkg::WORD_W:0]    shifted;
   logic [lcts_pkg::WORD_W:0]    diff;
   logic                         fits;

   // One restoring step: bring down the next dividend bit and try to subtract.
   always_comb begin
      shifted = {rem_ff, quo_ff[lcts_pkg::DVD_W-1]};
      diff    = shifted - {1'b0, divisor_ff};
      fits    = shifted >= {1'b0, divisor_ff};
   end

   // Next values of the step counter and the working registers.
   always_comb begin
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         count_in   = lcts_pkg::DIV_STEPS;
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         rem_in   = fits ? diff[lcts_pkg::WORD_W-1:0] : shifted[lcts_pkg::WORD_W-1:0];
         quo_in   = {quo_ff[lcts_pkg::DVD_W-2:0], fits};
      end
   end

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy      = count_ff != '0;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

### design/load_cell_tare_and_scale.sv
// ----------------------------------------------------------------------------
// load_cell_tare_and_scale: averaging, tare and scaling of bridge converter words
// Each accepted word is sign-extended, divided by the sample count and added
// into a batch sum. A tare batch stores the sum as the offset; a measure batch
// returns the net count and the net count over the Q16.16 scale as whole
// units and hundredths. All divisions share one restoring divider that
// produces one quotient bit per cycle over 48 steps. A new word is taken
// only once the sequencer has finished with the previous one: one divider
// pass for a word that does not close a batch or closes a tare batch, three
// divider passes in all for a word that closes a measure batch, plus any
// wait for the previous result to be taken. Configuration writes are
// accepted in every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module load_cell_tare_and_scale #(
   parameter int ADC_BITS = 24
) (
   input  wire              clock,
   input  wire              reset,
   lcts_req_if.sink         req_chan,
   lcts_rsp_if.source       rsp_chan,
   lcts_csr_if.sink         csr_chan
);

   // Configuration registers.
   logic [lcts_pkg::CNT_W-1:0]   sample_count_ff;
   logic [lcts_pkg::WORD_W-1:0]  scale_factor_ff;

   // Batch state.
   logic [lcts_pkg::WORD_W-1:0]  batch_sum_ff, batch_sum_in;
   logic [lcts_pkg::CNT_W-1:0]   batch_index_ff, batch_index_in;
   logic [lcts_pkg::WORD_W-1:0]  tare_offset_ff, tare_offset_in;
   logic                         mode_ff, mode_in;

   // Scaling scratch registers.
   logic [lcts_pkg::WORD_W-1:0]  net_ff, net_in;
   logic [lcts_pkg::WORD_W-1:0]  whole_ff, whole_in;
   logic [lcts_pkg::PROD_W-1:0]  prod_ff, prod_in;

   // Result register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lcts_pkg::WORD_W-1:0]  rsp_net_ff, rsp_net_in;
   logic [lcts_pkg::WORD_W-1:0]  rsp_whole_ff, rsp_whole_in;
   logic [lcts_pkg::CENT_W-1:0]  rsp_cent_ff, rsp_cent_in;

   // Sequencer.
   lcts_pkg::pc_type             pc_ff, pc_in;
   lcts_pkg::ctrl_word_type      cw;
   logic                         cond_true;

   // Divider link.
   lcts_pkg::div_req_type        div_req;
   lcts_pkg::div_rsp_type        div_rsp;

   logic signed [ADC_BITS-1:0]   raw_signed;
   logic [lcts_pkg::WORD_W-1:0]  word;
   logic [lcts_pkg::CNT_W-1:0]   count_eff;
   logic [lcts_pkg::WORD_W-1:0]  scale_eff;
   logic [lcts_pkg::WORD_W-1:0]  net_diff;
   logic [lcts_pkg::WORD_W-1:0]  net_clamped;
   logic                         batch_more;
   logic                         out_free;
   logic                         req_accept;

   lcts_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Operand preparation.
   always_comb begin
      raw_signed  = req_chan.raw_sample;
      word        = lcts_pkg::WORD_W'(raw_signed);
      count_eff   = (sample_count_ff == '0) ? lcts_pkg::CNT_W'(1) : sample_count_ff;
      scale_eff   = (scale_factor_ff == '0) ? lcts_pkg::WORD_W'(1) : scale_factor_ff;
      net_diff    = batch_sum_ff - tare_offset_ff;
      net_clamped = (net_diff > lcts_pkg::CLAMP_LIMIT) ? '0 : net_diff;
      batch_more  = ({1'b0, batch_index_ff} + 9'd1) < {1'b0, count_eff};
      out_free    = !rsp_valid_ff || rsp_chan.ready;
   end

   // Control word fetch and jump condition.
   always_comb begin
      cw = lcts_pkg::ucode_rom(pc_ff);
      case (cw.cond)
         lcts_pkg::COND_NEVER:      cond_true = 1'b0;
         lcts_pkg::COND_ALWAYS:     cond_true = 1'b1;
         lcts_pkg::COND_NO_REQ:     cond_true = !req_chan.valid;
         lcts_pkg::COND_DIV_BUSY:   cond_true = div_rsp.busy;
         lcts_pkg::COND_BATCH_MORE: cond_true = batch_more;
         lcts_pkg::COND_TARE:       cond_true = mode_ff;
         lcts_pkg::COND_OUT_BUSY:   cond_true = !out_free;
         default:                   cond_true = 1'b1;
      endcase
   end

   // Next step address.
   always_comb begin
      pc_in = cond_true ? cw.target : pc_ff + 1'b1;
   end

   assign req_chan.ready = (pc_ff == lcts_pkg::STEP_FETCH);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // Divider commands issued by the current control word.
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = scale_eff;
      case (cw.uop)
         lcts_pkg::UOP_LOAD_SAMPLE: begin
            div_req.start    = req_accept;
            div_req.dividend = lcts_pkg::DVD_W'(word);
            div_req.divisor  = lcts_pkg::WORD_W'(count_eff);
         end
         lcts_pkg::UOP_NET: begin
            div_req.start    = 1'b1;
            div_req.dividend = {net_clamped, {lcts_pkg::FRAC_W{1'b0}}};
         end
         lcts_pkg::UOP_FRAC: begin
            div_req.start    = 1'b1;
            div_req.dividend = lcts_pkg::DVD_W'(prod_ff);
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   // Datapath register updates issued by the current control word.
   always_comb begin
      batch_sum_in   = batch_sum_ff;
      batch_index_in = batch_index_ff;
      tare_offset_in = tare_offset_ff;
      mode_in        = mode_ff;
      net_in         = net_ff;
      whole_in       = whole_ff;
      prod_in        = prod_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_net_in     = rsp_net_ff;
      rsp_whole_in   = rsp_whole_ff;
      rsp_cent_in    = rsp_cent_ff;
      case (cw.uop)
         lcts_pkg::UOP_LOAD_SAMPLE: begin
            if (req_accept) begin
               mode_in = req_chan.mode;
            end
         end
         lcts_pkg::UOP_ACCUM: begin
            batch_sum_in   = batch_sum_ff + div_rsp.quotient[lcts_pkg::WORD_W-1:0];
            batch_index_in = batch_more ? batch_index_ff + 1'b1 : '0;
         end
         lcts_pkg::UOP_NET: begin
            net_in       = net_clamped;
            batch_sum_in = '0;
         end
         lcts_pkg::UOP_MUL: begin
            // Whole units saturate; the remainder carries the hundredths.
            whole_in = (div_rsp.quotient[lcts_pkg::DVD_W-1:lcts_pkg::WORD_W] != '0) ?
                       '1 : div_rsp.quotient[lcts_pkg::WORD_W-1:0];
            prod_in  = lcts_pkg::PROD_W'(div_rsp.remainder) *
                       lcts_pkg::PROD_W'(lcts_pkg::HUNDRED);
         end
         lcts_pkg::UOP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_net_in   = net_ff;
               rsp_whole_in = whole_ff;
               rsp_cent_in  = div_rsp.quotient[lcts_pkg::CENT_W-1:0];
            end
         end
         lcts_pkg::UOP_TARE: begin
            tare_offset_in = batch_sum_ff;
            batch_sum_in   = '0;
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff           <= lcts_pkg::STEP_FETCH;
         rsp_valid_ff    <= 1'b0;
         batch_sum_ff    <= '0;
         batch_index_ff  <= '0;
         tare_offset_ff  <= '0;
         sample_count_ff <= lcts_pkg::RESET_SAMPLE_COUNT;
         scale_factor_ff <= lcts_pkg::RESET_SCALE_FACTOR;
      end else begin
         pc_ff          <= pc_in;
         rsp_valid_ff   <= rsp_valid_in;
         batch_sum_ff   <= batch_sum_in;
         batch_index_ff <= batch_index_in;
         tare_offset_ff <= tare_offset_in;
         if (csr_chan.valid && csr_chan.ready) begin
            if (csr_chan.index == lcts_pkg::CSR_SAMPLE_COUNT) begin
               sample_count_ff <= csr_chan.data[lcts_pkg::CNT_W-1:0];
            end else if (csr_chan.index == lcts_pkg::CSR_SCALE_FACTOR) begin
               scale_factor_ff <= csr_chan.data;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      net_ff       <= net_in;
      whole_ff     <= whole_in;
      prod_ff      <= prod_in;
      rsp_net_ff   <= rsp_net_in;
      rsp_whole_ff <= rsp_whole_in;
      rsp_cent_ff  <= rsp_cent_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.net_counts  = rsp_net_ff;
   assign rsp_chan.whole_units = rsp_whole_ff;
   assign rsp_chan.hundredths  = rsp_cent_ff;

endmodule

`default_nettype wire
